### rtl/sadr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sadr_pkg
// Shared types and codes for the sample accumulate / deadband report unit.
// ----------------------------------------------------------------------------
package sadr_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned IN_DW   = 40;
  localparam int unsigned IN_UW   = 2;
  localparam int unsigned OUT_DW  = 40;
  localparam int unsigned DB_W    = 31;
  localparam int unsigned MODE_W  = 2;

  // register indexes
  localparam logic [ADDR_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [ADDR_W-1:0] CFG_MIN       = 3'd1;
  localparam logic [ADDR_W-1:0] CFG_MAX       = 3'd2;
  localparam logic [ADDR_W-1:0] CFG_DEADBAND  = 3'd3;
  localparam logic [ADDR_W-1:0] CFG_TRACK     = 3'd4;
  localparam logic [ADDR_W-1:0] CFG_SEND_EMPTY = 3'd5;

  // processing modes
  localparam logic [MODE_W-1:0] MODE_LATEST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AVG    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUM    = 2'd2;

  // actions
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_SEND   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DECIDE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               start;
    logic               neg;
    logic [VAL_W-1:0]   dividend;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [VAL_W-1:0]   quot;
  } div_rsp_t;

endpackage : sadr_pkg
`default_nettype wire

### rtl/sadr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sadr_div
// Restoring serial divider: signed 32-bit total by unsigned count, one
// quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module sadr_div #(
  parameter int unsigned CNT_W = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire sadr_pkg::div_req_t       req,
  input  wire [CNT_W-1:0]               divisor,
  output sadr_pkg::div_rsp_t            rsp
);

  localparam int unsigned STEP_W = $clog2(sadr_pkg::VAL_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(sadr_pkg::VAL_W - 1);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic                       neg_r;
  logic [STEP_W-1:0]          step_r;
  logic [sadr_pkg::VAL_W-1:0] dq_r;     // dividend shifts out, quotient shifts in
  logic [CNT_W-1:0]           rem_r;
  logic [CNT_W-1:0]           dvs_r;

  logic [CNT_W:0]             rem_sh;
  logic                       q_bit;
  logic [CNT_W:0]             rem_diff;

  always_comb begin
    rem_sh   = {rem_r, dq_r[sadr_pkg::VAL_W-1]};
    rem_diff = rem_sh - {1'b0, dvs_r};
    q_bit    = (rem_sh >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && (step_r == LAST_STEP)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (req.start) begin
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq_r  <= req.dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= req.neg;
    end else if (busy_r) begin
      dq_r  <= {dq_r[sadr_pkg::VAL_W-2:0], q_bit};
      rem_r <= q_bit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? (~dq_r + 1'b1) : dq_r;

endmodule : sadr_div
`default_nettype wire

### rtl/sample_accumulate_deadband_report_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sample_accumulate_deadband_report_unit
// Report-by-exception filter: accumulates Q16.16 samples and decides on each
// send request whether the processed value goes out.
// ----------------------------------------------------------------------------
// One word in, one word out. A word is taken only while the sequencer is idle.
// In latest and sum modes a sample word passes through the ACC and DONE steps
// before it reaches the output register, and a send request through DECIDE and
// DONE. In average mode the serial divider produces one quotient bit per cycle
// over the 32 bit total, and a sample word passes through ACC, DIV_GO, DIV_WAIT
// and DONE. An invalid sample goes from accept straight to DONE. The input is
// ready again once the result is in the output register, even if that word is
// not yet taken; a full output register that is not taken holds the sequencer
// in its last step. Pending count saturates at COUNT_MAX; the total saturates
// to 32 bits signed.
module sample_accumulate_deadband_report_unit #(
  parameter int unsigned COUNT_MAX = 65535
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // config
  input  wire                                 cfg_we,
  input  wire [sadr_pkg::ADDR_W-1:0]          cfg_addr,
  input  wire [sadr_pkg::VAL_W-1:0]           cfg_wdata,
  // input stream
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // [31:0] sample, [32] force_req, [33] first_run, [34] timer_over
  input  wire [sadr_pkg::IN_DW-1:0]           in_tdata,
  // [0] action, [1] sample_invalid
  input  wire [sadr_pkg::IN_UW-1:0]           in_tuser,
  // output stream
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [0] report, [32:1] value_out, [33] restart_timer
  output logic [sadr_pkg::OUT_DW-1:0]         out_tdata
);

  localparam int unsigned CNT_W = $clog2(COUNT_MAX + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(COUNT_MAX);
  localparam int unsigned CMP_W = sadr_pkg::VAL_W + 2;

  // configuration
  logic [sadr_pkg::MODE_W-1:0]  mode_r;
  logic signed [sadr_pkg::VAL_W-1:0] min_r, max_r;
  logic [sadr_pkg::DB_W-1:0]    db_r;
  logic                         track_r, send_empty_r;

  // state
  sadr_pkg::state_t             state_r, state_nxt;
  logic signed [sadr_pkg::VAL_W-1:0] total_r, cur_r, last_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         out_valid_r;
  logic                         rpt_r, rst_tmr_r;

  // latched input word
  logic                         act_r, inv_r, force_r, first_r, tmo_r;
  logic signed [sadr_pkg::VAL_W-1:0] smp_r;

  sadr_pkg::div_req_t           div_req;
  sadr_pkg::div_rsp_t           div_rsp;

  logic                         in_acc, out_acc, out_free;

  // accumulate
  logic signed [sadr_pkg::VAL_W-1:0] base_tot, sat_tot;
  logic signed [sadr_pkg::VAL_W:0]   sum_w;
  logic                         accum_mode;

  // decision
  logic signed [sadr_pkg::VAL_W-1:0] last_eff;
  logic signed [CMP_W-1:0]      cur_x, band_lo, band_hi;
  logic                         gate_empty, out_range, in_band, report_nxt;

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign out_free = !out_valid_r || out_tready;

  // ---------------- config port ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= sadr_pkg::MODE_LATEST;
      min_r        <= {1'b1, {(sadr_pkg::VAL_W-1){1'b0}}};
      max_r        <= {1'b0, {(sadr_pkg::VAL_W-1){1'b1}}};
      db_r         <= '0;
      track_r      <= 1'b0;
      send_empty_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sadr_pkg::CFG_MODE:       mode_r       <= cfg_wdata[sadr_pkg::MODE_W-1:0];
        sadr_pkg::CFG_MIN:        min_r        <= cfg_wdata;
        sadr_pkg::CFG_MAX:        max_r        <= cfg_wdata;
        sadr_pkg::CFG_DEADBAND:   db_r         <= cfg_wdata[sadr_pkg::DB_W-1:0];
        sadr_pkg::CFG_TRACK:      track_r      <= cfg_wdata[0];
        sadr_pkg::CFG_SEND_EMPTY: send_empty_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------- datapath logic ----------------
  always_comb begin
    accum_mode = (mode_r == sadr_pkg::MODE_AVG) || (mode_r == sadr_pkg::MODE_SUM);
    base_tot   = (cnt_r == '0) ? '0 : total_r;
    sum_w      = {base_tot[sadr_pkg::VAL_W-1], base_tot} + {smp_r[sadr_pkg::VAL_W-1], smp_r};
    // overflow when the two top bits differ
    if (sum_w[sadr_pkg::VAL_W] != sum_w[sadr_pkg::VAL_W-1]) begin
      sat_tot = sum_w[sadr_pkg::VAL_W] ? {1'b1, {(sadr_pkg::VAL_W-1){1'b0}}}
                                       : {1'b0, {(sadr_pkg::VAL_W-1){1'b1}}};
    end else begin
      sat_tot = sum_w[sadr_pkg::VAL_W-1:0];
    end

    last_eff   = track_r ? cur_r : last_r;
    cur_x      = CMP_W'(cur_r);
    band_lo    = CMP_W'(last_eff) - CMP_W'({1'b0, db_r});
    band_hi    = CMP_W'(last_eff) + CMP_W'({1'b0, db_r});
    gate_empty = !send_empty_r && (cnt_r == '0);
    out_range  = (cur_r < min_r) || (cur_r > max_r);
    in_band    = (cur_x > band_lo) && (cur_x < band_hi);
    priority if (force_r) begin
      report_nxt = 1'b1;
    end else if (gate_empty) begin
      report_nxt = 1'b0;
    end else if (first_r) begin
      report_nxt = 1'b1;
    end else if (out_range) begin
      report_nxt = 1'b0;
    end else begin
      report_nxt = tmo_r || !in_band;
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sadr_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == sadr_pkg::ACT_SEND) begin
            state_nxt = sadr_pkg::S_DECIDE;
          end else if (in_tuser[1]) begin
            state_nxt = sadr_pkg::S_DONE;
          end else begin
            state_nxt = sadr_pkg::S_ACC;
          end
        end
      end
      sadr_pkg::S_ACC: begin
        state_nxt = (mode_r == sadr_pkg::MODE_AVG) ? sadr_pkg::S_DIV_GO : sadr_pkg::S_DONE;
      end
      sadr_pkg::S_DIV_GO:   state_nxt = sadr_pkg::S_DIV_WAIT;
      sadr_pkg::S_DIV_WAIT: if (div_rsp.done) state_nxt = sadr_pkg::S_DONE;
      sadr_pkg::S_DECIDE:   state_nxt = sadr_pkg::S_DONE;
      sadr_pkg::S_DONE:     if (out_free) state_nxt = sadr_pkg::S_IDLE;
      default:              state_nxt = sadr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready        = (state_r == sadr_pkg::S_IDLE);
    div_req.start    = (state_r == sadr_pkg::S_DIV_GO);
    div_req.neg      = total_r[sadr_pkg::VAL_W-1];
    div_req.dividend = total_r[sadr_pkg::VAL_W-1] ? (~total_r + 1'b1) : total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sadr_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      cur_r       <= '0;
      cnt_r       <= '0;
      last_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == sadr_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        sadr_pkg::S_ACC: begin
          total_r <= accum_mode ? sat_tot : base_tot;
          if (cnt_r != CNT_MAX) cnt_r <= cnt_r + 1'b1;
          if (mode_r == sadr_pkg::MODE_SUM) begin
            cur_r <= sat_tot;
          end else if (mode_r != sadr_pkg::MODE_AVG) begin
            cur_r <= smp_r;
          end
        end
        sadr_pkg::S_DIV_WAIT: begin
          if (div_rsp.done) cur_r <= div_rsp.quot;
        end
        sadr_pkg::S_DECIDE: begin
          if (report_nxt) begin
            last_r <= cur_r;
            cnt_r  <= '0;
          end else begin
            last_r <= last_eff;
          end
        end
        default: ;
      endcase
    end
  end

  // input word capture and result flags
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r   <= in_tuser[0];
      inv_r   <= in_tuser[1];
      smp_r   <= in_tdata[sadr_pkg::VAL_W-1:0];
      force_r <= in_tdata[32];
      first_r <= in_tdata[33];
      tmo_r   <= in_tdata[34];
      rpt_r     <= 1'b0;
      rst_tmr_r <= 1'b0;
    end else if (state_r == sadr_pkg::S_DECIDE) begin
      rpt_r     <= report_nxt;
      rst_tmr_r <= report_nxt && tmo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sadr_pkg::S_DONE && out_free) begin
      out_tdata <= {6'd0, rst_tmr_r, cur_r, rpt_r};
    end
  end

  assign out_tvalid = out_valid_r;

  sadr_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .divisor (cnt_r),
    .rsp     (div_rsp)
  );

`ifndef ASSERT_OFF
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == sadr_pkg::S_DIV_WAIT))
    else $error("divider finished outside wait state");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("pending count above limit");

  a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sadr_pkg::S_DECIDE && report_nxt) |=> (cnt_r == '0))
    else $error("report did not clear pending count");

  a_restart_needs_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tdata[33]) |-> out_tdata[0])
    else $error("timer restart without report");

  a_sample_no_report: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sadr_pkg::S_DONE && act_r == sadr_pkg::ACT_SAMPLE) |-> !rpt_r)
    else $error("sample word flagged as report");

  a_invalid_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sadr_pkg::S_IDLE && in_acc && in_tuser[0] == sadr_pkg::ACT_SAMPLE
     && in_tuser[1]) |=> (state_r == sadr_pkg::S_DONE && inv_r))
    else $error("invalid sample entered accumulation");
`endif

endmodule : sample_accumulate_deadband_report_unit
`default_nettype wire
